// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ----- sv/pbva_pkg.sv -----
// Package with the types, codes and lane helpers of the packed byte vector ALU.
package pbva_pkg;

    localparam int WORD_W    = 64;
    localparam int LANE_W    = 8;
    localparam int LANES_MAX = WORD_W / LANE_W;
    localparam int LANES_DEF = 8;
    localparam int FUNC_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int LAT_W     = 8;
    // One iteration per bit of a lane for divide and multiply.
    localparam int STEPS     = LANE_W;
    localparam int STEP_W    = $clog2(STEPS + 1);
    localparam logic [LAT_W-1:0] LATENCY_RST = LAT_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_MUL     = 4'd2,
        FN_DIVU    = 4'd3,
        FN_REMU    = 4'd4,
        FN_EQ      = 4'd5,
        FN_LES     = 4'd6,
        FN_LTU     = 4'd7,
        FN_LTS     = 4'd8,
        FN_LTU_ALT = 4'd9
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_BADFN = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    // Control from the sequencer to every lane unit.
    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

    // Combinational lane operations: add, subtract and the compares.
    function automatic logic [LANE_W-1:0] simple_op(
        input logic [LANE_W-1:0] a,
        input logic [LANE_W-1:0] b,
        input func_t             fn
    );
        logic [LANE_W-1:0] r;
        r = '0;
        case (fn) inside
            FN_ADD:              r = a + b;
            FN_SUB:              r = a - b;
            FN_EQ:               r = LANE_W'(a == b);
            FN_LES:              r = LANE_W'($signed(a) <= $signed(b));
            FN_LTS:              r = LANE_W'($signed(a) < $signed(b));
            FN_LTU, FN_LTU_ALT:  r = LANE_W'(a < b);
            default:             r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/pbva_ifs.sv -----
// Valid/ready channel interfaces for requests, responses and the latency register.
interface pbva_req_if;
    logic                               valid;
    logic                               ready;
    logic [pbva_pkg::WORD_W-1:0]        operand_a;
    logic [pbva_pkg::WORD_W-1:0]        operand_b;
    logic [pbva_pkg::FUNC_W-1:0]        func;

    modport source (output valid, output operand_a, output operand_b, output func,
                    input ready);
    modport sink   (input valid, input operand_a, input operand_b, input func,
                    output ready);
endinterface

interface pbva_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [pbva_pkg::WORD_W-1:0]        lane_result;
    logic [pbva_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output lane_result, output status, input ready);
    modport sink   (input valid, input lane_result, input status, output ready);
endinterface

interface pbva_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pbva_pkg::LAT_W-1:0]         data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/packed_byte_vector_alu.sv -----
// A busy or bad-function word is in the output register in the cycle after acceptance.
// For a computed word the lanes load at acceptance, step through the bit-serial divide and
// shift-add multiply loop, and the output register takes the lane results once the loop
// has ended and the output is free. Busy and error words go at one per cycle while the
// output is free; no new request is taken while a word is computing.
// Reset clears the sequencer and output valid, and loads latency and the countdown with LATENCY_RST.
`include "assert_macros.svh"

module packed_byte_vector_alu #(
    parameter int LANES = pbva_pkg::LANES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pbva_req_if.sink    req,
    pbva_rsp_if.source  rsp,
    pbva_cfg_if.sink    cfg
);

    localparam int LANE_W = pbva_pkg::LANE_W;
    localparam int WORD_W = pbva_pkg::WORD_W;
    localparam int LAT_W  = pbva_pkg::LAT_W;
    localparam int STEP_W = pbva_pkg::STEP_W;

    pbva_pkg::state_t                   state_reg, state_next;
    logic [STEP_W-1:0]                  cnt_reg, cnt_next;
    logic [LAT_W-1:0]                   latency_reg, latency_next;
    logic [LAT_W-1:0]                   count_reg, count_next;
    pbva_pkg::func_t                    fn_reg, fn_next;
    logic                               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]                  res_reg, res_next;
    pbva_pkg::status_t                  status_reg, status_next;

    logic                               req_ready;
    logic                               req_fire;
    logic                               cfg_fire;
    logic                               func_ok;
    logic [LAT_W-1:0]                   dec;
    logic                               run_done;
    logic                               out_free;
    pbva_pkg::lane_ctl_t                lane_ctl;
    pbva_pkg::func_t                    req_fn;
    logic [LANES*LANE_W-1:0]            lanes_res;

    // Handshake and decode of the incoming word.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req_ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign func_ok   = (req.func <= pbva_pkg::FUNC_W'(pbva_pkg::FN_LTU_ALT));
    assign req_fn    = pbva_pkg::func_t'(req.func);
    assign dec       = (count_reg == '0) ? '0 : count_reg - LAT_W'(1);
    assign run_done  = (cnt_reg == STEP_W'(pbva_pkg::STEPS));

    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.lane_result = res_reg;
    assign rsp.status      = status_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbva_pkg::S_IDLE:
            begin
                if (req_fire && func_ok && dec == '0)
                    state_next = pbva_pkg::S_RUN;
            end
            pbva_pkg::S_RUN:
            begin
                if (run_done && out_free)
                    state_next = pbva_pkg::S_IDLE;
            end
            default: state_next = pbva_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req_ready     = 1'b0;
        lane_ctl.load = 1'b0;
        lane_ctl.step = 1'b0;
        unique case (state_reg)
            pbva_pkg::S_IDLE:
            begin
                req_ready     = out_free;
                lane_ctl.load = req.valid && out_free && func_ok;
            end
            pbva_pkg::S_RUN:
            begin
                lane_ctl.step = !run_done;
            end
            default: req_ready = 1'b0;
        endcase
    end

    // Step counter, latency register, countdown and output register.
    always_comb
    begin
        cnt_next       = cnt_reg;
        latency_next   = latency_reg;
        count_next     = count_reg;
        fn_next        = fn_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        status_next    = status_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        if (cfg_fire)
        begin
            latency_next = cfg.data;
            count_next   = cfg.data;
        end

        if (lane_ctl.load)
            cnt_next = '0;
        else if (lane_ctl.step)
            cnt_next = cnt_reg + STEP_W'(1);

        if (req_fire)
        begin
            if (!func_ok)
            begin
                out_valid_next = 1'b1;
                res_next       = '0;
                status_next    = pbva_pkg::ST_BADFN;
            end
            else if (dec != '0)
            begin
                count_next     = dec;
                out_valid_next = 1'b1;
                res_next       = '0;
                status_next    = pbva_pkg::ST_BUSY;
            end
            else
            begin
                // The countdown reloads now; the word leaves when the loop ends.
                count_next = latency_reg;
                fn_next    = req_fn;
            end
        end

        if (state_reg == pbva_pkg::S_RUN && run_done && out_free)
        begin
            out_valid_next = 1'b1;
            res_next       = WORD_W'(lanes_res);
            status_next    = pbva_pkg::ST_DONE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbva_pkg::S_IDLE;
            cnt_reg       <= '0;
            latency_reg   <= pbva_pkg::LATENCY_RST;
            count_reg     <= pbva_pkg::LATENCY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            latency_reg   <= latency_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fn_reg     <= fn_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    // One lane unit per byte lane.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        pbva_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .a      (req.operand_a[i*LANE_W +: LANE_W]),
            .b      (req.operand_b[i*LANE_W +: LANE_W]),
            .fn     (req_fn),
            .fn_run (fn_reg),
            .res    (lanes_res[i*LANE_W +: LANE_W])
        );
    end

    // Checks on the result path and the countdown.
    `ASSERT_IMPL(a_zero_unless_done,
        rsp.valid && rsp.status != pbva_pkg::ST_DONE, rsp.lane_result == '0,
        "lane result not zero on a busy or error word")
    `ASSERT_NEXT(a_busy_word,
        req_fire && func_ok && count_reg > LAT_W'(1),
        rsp.valid && rsp.status == pbva_pkg::ST_BUSY,
        "counting request did not give a busy word")
    `ASSERT_NEXT(a_badfn_keeps_count,
        req_fire && !func_ok && !cfg_fire,
        rsp.valid && rsp.status == pbva_pkg::ST_BADFN && $stable(count_reg),
        "bad function code changed the countdown or lost its word")
    `ASSERT_CLK(a_step_bound, cnt_reg <= STEP_W'(pbva_pkg::STEPS),
        "step counter ran past the lane width")

endmodule

// ----- sv/pbva_lane.sv -----
// One byte lane: bit-serial restoring divider, shift-add multiplier and simple ops.
module pbva_lane (
    input  logic                            clk,
    input  pbva_pkg::lane_ctl_t             ctl,
    input  logic [pbva_pkg::LANE_W-1:0]     a,
    input  logic [pbva_pkg::LANE_W-1:0]     b,
    input  pbva_pkg::func_t                 fn,
    input  pbva_pkg::func_t                 fn_run,
    output logic [pbva_pkg::LANE_W-1:0]     res
);

    localparam int W = pbva_pkg::LANE_W;

    logic [W-1:0] dvd_reg,    dvd_next;
    logic [W-1:0] rem_reg,    rem_next;
    logic [W-1:0] div_reg,    div_next;
    logic [W-1:0] mcand_reg,  mcand_next;
    logic [W-1:0] mplier_reg, mplier_next;
    logic [W-1:0] acc_reg,    acc_next;
    logic [W-1:0] simple_reg, simple_next;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         ge;

    // One restoring division step: bring in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = (shifted >= {1'b0, div_reg});

    // Next values for load, step and hold.
    always_comb
    begin
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        simple_next = simple_reg;
        if (ctl.load)
        begin
            dvd_next    = a;
            rem_next    = '0;
            div_next    = b;
            mcand_next  = a;
            mplier_next = b;
            acc_next    = '0;
            simple_next = pbva_pkg::simple_op(a, b, fn);
        end
        else if (ctl.step)
        begin
            // The quotient shifts in where the dividend bits leave.
            dvd_next    = {dvd_reg[W-2:0], ge};
            rem_next    = ge ? diff[W-1:0] : shifted[W-1:0];
            acc_next    = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
            mcand_next  = {mcand_reg[W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[W-1:1]};
        end
    end

    // Lane datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        simple_reg <= simple_next;
    end

    // Pick the lane result for the operation in flight.
    always_comb
    begin
        case (fn_run)
            pbva_pkg::FN_MUL:  res = acc_reg;
            pbva_pkg::FN_DIVU: res = dvd_reg;
            pbva_pkg::FN_REMU: res = rem_reg;
            default:           res = simple_reg;
        endcase
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the packed byte vector ALU with directed and random words.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES       = pbva_pkg::LANES_DEF;
    localparam int LANE_W      = pbva_pkg::LANE_W;
    localparam int WORD_W      = pbva_pkg::WORD_W;
    localparam int LAT_W       = pbva_pkg::LAT_W;
    localparam int FUNC_W      = pbva_pkg::FUNC_W;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 240;
    localparam int TAIL_CYCLES = 12;

    // One expected response word.
    typedef struct {
        logic [WORD_W-1:0] lane_result;
        pbva_pkg::status_t status;
    } alu_word_t;

    // Tracks the latency countdown and holds the expected response words in order.
    class alu_scoreboard;
        logic [LAT_W-1:0] latency;
        logic [LAT_W-1:0] countdown;
        alu_word_t        expected_q[$];
        int               failures;

        function new();
            latency   = pbva_pkg::LATENCY_RST;
            countdown = pbva_pkg::LATENCY_RST;
            failures  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // A latency write also reloads the countdown.
        function void note_latency(logic [LAT_W-1:0] value);
            latency   = value;
            countdown = value;
        endfunction

        function logic [LANE_W-1:0] lane_value(logic [LANE_W-1:0] a, logic [LANE_W-1:0] b,
                                               pbva_pkg::func_t op);
            logic [LANE_W-1:0] r;
            r = '0;
            case (op) inside
                pbva_pkg::FN_ADD:  r = a + b;
                pbva_pkg::FN_SUB:  r = a - b;
                pbva_pkg::FN_MUL:  r = a * b;
                pbva_pkg::FN_DIVU: r = (b == '0) ? '1 : a / b;
                pbva_pkg::FN_REMU: r = (b == '0) ? a : a % b;
                pbva_pkg::FN_EQ:   r = {{(LANE_W-1){1'b0}}, a == b};
                pbva_pkg::FN_LES:  r = {{(LANE_W-1){1'b0}}, $signed(a) <= $signed(b)};
                pbva_pkg::FN_LTS:  r = {{(LANE_W-1){1'b0}}, $signed(a) < $signed(b)};
                pbva_pkg::FN_LTU, pbva_pkg::FN_LTU_ALT:
                                   r = {{(LANE_W-1){1'b0}}, a < b};
                default:           r = '0;
            endcase
            return r;
        endfunction

        // Works out the response to an accepted request word.
        function void note_request(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                   logic [FUNC_W-1:0] fn);
            alu_word_t w;
            w.lane_result = '0;
            w.status      = pbva_pkg::ST_BUSY;
            if (fn > pbva_pkg::FN_LTU_ALT)
            begin
                // A bad function code leaves the countdown alone.
                w.status = pbva_pkg::ST_BADFN;
            end
            else
            begin
                if (countdown != '0)
                    countdown = countdown - 1'b1;
                if (countdown == '0)
                begin
                    for (int i = 0; i < LANES; i++)
                        w.lane_result[i*LANE_W +: LANE_W] =
                            lane_value(a[i*LANE_W +: LANE_W], b[i*LANE_W +: LANE_W],
                                       pbva_pkg::func_t'(fn));
                    w.status  = pbva_pkg::ST_DONE;
                    countdown = latency;
                end
            end
            expected_q.push_back(w);
        endfunction

        // Compares a response word with the oldest expectation.
        function void check_response(logic [WORD_W-1:0] res,
                                     logic [pbva_pkg::STATUS_W-1:0] st);
            alu_word_t w;
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: lane_result %h, status %0d", res, st);
                failures++;
                return;
            end
            w = expected_q.pop_front();
            if (res !== w.lane_result)
            begin
                $error("lane_result: expected %h, actual %h", w.lane_result, res);
                failures++;
            end
            if (st !== w.status)
            begin
                $error("status: expected %0d, actual %0d", w.status, st);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;
    logic [LAT_W-1:0] latency_plan [PHASES] = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd7, 8'd0,
                                                8'd1, 8'd4};
    alu_scoreboard sb = new();

    pbva_req_if req_ch();
    pbva_rsp_if rsp_ch();
    pbva_cfg_if cfg_ch();

    packed_byte_vector_alu #(.LANES(LANES)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random, one decision per cycle.
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watch every channel at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.note_latency(cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.operand_a, req_ch.operand_b, req_ch.func);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.lane_result, rsp_ch.status);
        end
    end

    // End the run when no word moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready)
            || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drives one request word, with random idle cycles ahead of it.
    task automatic send_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                             input logic [FUNC_W-1:0] fn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        req_ch.func      <= fn;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending until every expected word has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_latency(input logic [LAT_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Byte values weighted toward the lane extremes.
    function automatic logic [WORD_W-1:0] random_operand();
        logic [WORD_W-1:0] v;
        v = '0;
        for (int i = 0; i < pbva_pkg::LANES_MAX; i++)
        begin
            case ($urandom_range(7))
                0:       v[i*LANE_W +: LANE_W] = 8'h00;
                1:       v[i*LANE_W +: LANE_W] = 8'hff;
                2:       v[i*LANE_W +: LANE_W] = 8'h80;
                3:       v[i*LANE_W +: LANE_W] = 8'h7f;
                4:       v[i*LANE_W +: LANE_W] = 8'h01;
                default: v[i*LANE_W +: LANE_W] = LANE_W'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [FUNC_W-1:0] random_func();
        if ($urandom_range(99) < 8)
            return FUNC_W'($urandom_range(10, 15));
        return FUNC_W'($urandom_range(int'(pbva_pkg::FN_ADD), int'(pbva_pkg::FN_LTU_ALT)));
    endfunction

    initial
    begin
        rst_n            = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        quiet_cycles     = 0;
        req_ch.valid     = 1'b0;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        req_ch.func      = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        latency_plan[5]  = LAT_W'($urandom_range(3, 254));
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every operation on lanes that hold the extremes, at the reset latency.
        for (int f = int'(pbva_pkg::FN_ADD); f <= int'(pbva_pkg::FN_LTU_ALT); f++)
            send_word(64'hff80_7f01_00fe_8001, 64'h0180_ff7f_00ff_0102, FUNC_W'(f));
        // Division by zero in some lanes, with nonzero dividends.
        send_word(64'h1234_5678_9abc_def0, 64'h0000_0003_0000_ff00, pbva_pkg::FN_DIVU);
        send_word(64'h1234_5678_9abc_def0, 64'h0000_0003_0000_ff00, pbva_pkg::FN_REMU);
        send_word('1, '1, pbva_pkg::FN_ADD);
        send_word('1, '1, pbva_pkg::FN_MUL);
        send_word('0, '1, pbva_pkg::FN_SUB);
        send_word({8{8'h80}}, {8{8'h7f}}, pbva_pkg::FN_LTS);
        send_word({8{8'h7f}}, {8{8'h80}}, pbva_pkg::FN_LES);
        // Bad function codes.
        send_word('1, '1, FUNC_W'(10));
        send_word('1, '1, '1);
        // A zero latency makes every word with a valid code done.
        write_latency(8'd0);
        send_word(random_operand(), random_operand(), pbva_pkg::FN_ADD);
        send_word(random_operand(), random_operand(), FUNC_W'(12));
        send_word(random_operand(), 64'h0, pbva_pkg::FN_DIVU);
        // A bad code between a busy word and a done word leaves the countdown alone.
        write_latency(8'd2);
        send_word(random_operand(), random_operand(), pbva_pkg::FN_MUL);
        send_word(random_operand(), random_operand(), FUNC_W'(14));
        send_word(random_operand(), random_operand(), pbva_pkg::FN_EQ);

        // Random phases, each with a latency from the plan and one of four idling patterns.
        for (int p = 0; p < PHASES; p++)
        begin
            write_latency(latency_plan[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(59) == 0)
                    wait_drained();
                send_word(random_operand(), random_operand(), random_func());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/pbva_pkg.sv
sv/pbva_ifs.sv
sv/pbva_lane.sv
sv/packed_byte_vector_alu.sv
tb/tb.sv
